// ===== src/mrcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrcd_pkg: shared types and constants of the memo result checker
// Event codes, sequencer states, default store depths and the per-kind
// constants of the report hash.
// ----------------------------------------------------------------------------
package mrcd_pkg;

  localparam int MEMO_DEPTH_DEF  = 1024;
  localparam int BLOOM_DEPTH_DEF = 1024;

  localparam int DATA_W = 64;
  localparam int OP_W   = 3;

  // Bit position inside a filter word comes from the low hash bits.
  localparam int BIT_SEL_W = 6;

  // Kind names are held right-justified in a packed vector of this width.
  localparam int NAME_CHARS = 20;
  localparam int NAME_W     = 8 * NAME_CHARS;

  typedef enum logic [OP_W-1:0] {
    OP_PURE        = 3'd0,
    OP_OVERFLOW    = 3'd1,
    OP_UNREACHABLE = 3'd2,
    OP_BOUNDS      = 3'd3,
    OP_SIGN_CONV   = 3'd4,
    OP_DIV_ZERO    = 3'd5,
    OP_LOOP_BOUND  = 3'd6,
    OP_UNUSED      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_HASH,
    ST_BRD,
    ST_DEC
  } state_t;

  // 31^len mod 2^64 for a kind name: factor applied to the site value.
  function automatic logic [DATA_W-1:0] kind_mul(input logic [NAME_W-1:0] name);
    logic [DATA_W-1:0] m;
    m = 64'd1;
    for (int i = NAME_CHARS - 1; i >= 0; i--) begin
      if (name[i*8 +: 8] != 8'd0) begin
        m = m * 64'd31;
      end
    end
    return m;
  endfunction

  // Polynomial sum of the name characters with a zero seed.
  function automatic logic [DATA_W-1:0] kind_add(input logic [NAME_W-1:0] name);
    logic [DATA_W-1:0] h;
    h = 64'd0;
    for (int i = NAME_CHARS - 1; i >= 0; i--) begin
      if (name[i*8 +: 8] != 8'd0) begin
        h = h * 64'd31 + {56'd0, name[i*8 +: 8]};
      end
    end
    return h;
  endfunction

  // Indexed by event code; the unused code never reaches the filter.
  localparam logic [DATA_W-1:0] KIND_MUL [8] = '{
    kind_mul({"pure", "_inconsistency"}),
    kind_mul("overflow"),
    kind_mul("unreachable"),
    kind_mul({"bounds", "_violation"}),
    kind_mul({"sign", "_conversion"}),
    kind_mul({"division", "_by_zero"}),
    kind_mul({"loop", "_bound_exceeded"}),
    64'd0
  };

  localparam logic [DATA_W-1:0] KIND_ADD [8] = '{
    kind_add({"pure", "_inconsistency"}),
    kind_add("overflow"),
    kind_add("unreachable"),
    kind_add({"bounds", "_violation"}),
    kind_add({"sign", "_conversion"}),
    kind_add({"division", "_by_zero"}),
    kind_add({"loop", "_bound_exceeded"}),
    64'd0
  };

endpackage

// ===== src/mrcd_kind_hash.sv =====
// ----------------------------------------------------------------------------
// mrcd_kind_hash: report hash of a site and a fault kind
// Computes site * 31^len + name_sum mod 2^64 with 32-bit partial products,
// two register stages. Inputs must hold for two cycles.
// ----------------------------------------------------------------------------
module mrcd_kind_hash
  import mrcd_pkg::*;
(
  input  logic              clk,
  input  logic [DATA_W-1:0] site,
  input  op_t               kind,
  output logic [DATA_W-1:0] key
);

  localparam int HALF_W = DATA_W / 2;

  logic [DATA_W-1:0] mul_c;
  logic [DATA_W-1:0] lo_prod_nxt;
  logic [DATA_W-1:0] cross_a;
  logic [DATA_W-1:0] cross_b;
  logic [HALF_W-1:0] cross_nxt;

  logic [DATA_W-1:0] lo_prod_r;
  logic [HALF_W-1:0] cross_r;
  logic [DATA_W-1:0] add_r;
  logic [DATA_W-1:0] key_r;

  assign mul_c       = KIND_MUL[kind];
  assign lo_prod_nxt = site[HALF_W-1:0] * mul_c[HALF_W-1:0];
  assign cross_a     = site[DATA_W-1:HALF_W] * mul_c[HALF_W-1:0];
  assign cross_b     = site[HALF_W-1:0] * mul_c[DATA_W-1:HALF_W];
  // Only the low half of the cross terms survives the shift.
  assign cross_nxt   = cross_a[HALF_W-1:0] + cross_b[HALF_W-1:0];

  always_ff @(posedge clk) begin
    lo_prod_r <= lo_prod_nxt;
    cross_r   <= cross_nxt;
    add_r     <= KIND_ADD[kind];
    key_r     <= lo_prod_r + {cross_r, {HALF_W{1'b0}}} + add_r;
  end

  assign key = key_r;

endmodule

// ===== src/memo_result_checker_with_dedup.sv =====
// ----------------------------------------------------------------------------
// memo_result_checker_with_dedup: memo consistency checker with report filter
// Sequencing: the block takes a new transaction only while idle, after the
// four-step sequence of memo read, hash, filter read and read-modify-write;
// the last step waits until the result register can take the result.
// Reset: after rst_n the block sweeps both stores, max(BLOOM_DEPTH,
// MEMO_DEPTH) addresses, with in_ready low; then it takes transactions.
// ----------------------------------------------------------------------------
module memo_result_checker_with_dedup
  import mrcd_pkg::*;
#(
  // Both depths must be powers of two between 16 and 65536; the block does not check.
  parameter int BLOOM_DEPTH = BLOOM_DEPTH_DEF,
  parameter int MEMO_DEPTH  = MEMO_DEPTH_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [DATA_W-1:0]        in_pc,
  input  logic [DATA_W-1:0]        in_func_hash,
  input  logic signed [DATA_W-1:0] in_arg_first,
  input  logic signed [DATA_W-1:0] in_arg_second,
  input  logic signed [DATA_W-1:0] in_call_result,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_emit_report,
  output logic                     out_mismatch,
  output logic signed [DATA_W-1:0] out_prior_result
);

  localparam int BAW       = $clog2(BLOOM_DEPTH);
  localparam int MAW       = $clog2(MEMO_DEPTH);
  localparam int CLR_DEPTH = (BLOOM_DEPTH > MEMO_DEPTH) ? BLOOM_DEPTH : MEMO_DEPTH;
  localparam int CW        = $clog2(CLR_DEPTH);
  localparam int CNT_W     = CW + 1;
  // Memo word: valid, key hash, first arg, second arg, result.
  localparam int MEMO_W    = 1 + 4 * DATA_W;

  // --------------------------------------------------------------------------
  // Stores: filter words and memo slots, registered reads
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] bloom_mem [BLOOM_DEPTH];
  logic [MEMO_W-1:0] memo_mem  [MEMO_DEPTH];

  logic              bloom_re;
  logic              bloom_we;
  logic [BAW-1:0]    bloom_ra;
  logic [BAW-1:0]    bloom_wa;
  logic [DATA_W-1:0] bloom_wd;
  logic [DATA_W-1:0] bloom_rd_r;

  logic              memo_re;
  logic              memo_we;
  logic [MAW-1:0]    memo_idx;
  logic [MAW-1:0]    memo_wa;
  logic [MEMO_W-1:0] memo_wd;
  logic [MEMO_W-1:0] memo_rd_r;

  always_ff @(posedge clk) begin
    if (bloom_we) begin
      bloom_mem[bloom_wa] <= bloom_wd;
    end
    if (bloom_re) begin
      bloom_rd_r <= bloom_mem[bloom_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (memo_we) begin
      memo_mem[memo_wa] <= memo_wd;
    end
    if (memo_re) begin
      memo_rd_r <= memo_mem[memo_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and held transaction
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;
  logic [CW-1:0] clr_cnt_r;
  logic          clr_last;

  op_t                     op_r;
  logic [DATA_W-1:0]       pc_r;
  logic [DATA_W-1:0]       fh_r;
  logic signed [DATA_W-1:0] a0_r;
  logic signed [DATA_W-1:0] a1_r;
  logic signed [DATA_W-1:0] res_r;

  logic                    hit_r;
  logic                    mis_r;
  logic signed [DATA_W-1:0] prior_r;

  logic                    out_valid_r;
  logic                    emit_r;
  logic                    mis_out_r;
  logic signed [DATA_W-1:0] prior_out_r;

  logic in_fire;
  logic out_free;
  logic cmp_load;
  logic out_load;
  logic clr_step;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign clr_last = (clr_cnt_r == CW'(CLR_DEPTH - 1));

  // Memo index: low bits of the hash mixed with both arguments.
  logic [DATA_W-1:0] memo_mix;
  assign memo_mix = fh_r ^ a0_r ^ {a1_r[DATA_W-17:0], 16'd0};
  assign memo_idx = memo_mix[MAW-1:0];

  // Report hash of the held transaction, registered inside the hash unit.
  logic [DATA_W-1:0] rep_key;

  mrcd_kind_hash u_kind_hash (
    .clk  (clk),
    .site (pc_r),
    .kind (op_r),
    .key  (rep_key)
  );

  // Memo slot compare against the held call.
  logic              slot_valid;
  logic [DATA_W-1:0] slot_key;
  logic [DATA_W-1:0] slot_a0;
  logic [DATA_W-1:0] slot_a1;
  logic [DATA_W-1:0] slot_res;
  logic              slot_hit;

  assign {slot_valid, slot_key, slot_a0, slot_a1, slot_res} = memo_rd_r;
  assign slot_hit = slot_valid && (slot_key == fh_r) && (slot_a0 == a0_r)
                    && (slot_a1 == a1_r);

  // Filter decision for the held event.
  logic [DATA_W-1:0] bit_mask;
  logic              do_filter;
  logic              bit_seen;
  logic              emit_c;

  assign bit_mask  = DATA_W'(1) << rep_key[BIT_SEL_W-1:0];
  assign do_filter = (op_r == OP_PURE) ? mis_r
                                       : (op_r != OP_UNUSED);
  assign bit_seen  = |(bloom_rd_r & bit_mask);
  assign emit_c    = do_filter && !bit_seen;
  assign bloom_ra  = rep_key[BIT_SEL_W +: BAW];

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_HASH;
      ST_HASH:  state_nxt = ST_BRD;
      ST_BRD:   state_nxt = ST_DEC;
      ST_DEC:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    memo_re  = 1'b0;
    bloom_re = 1'b0;
    cmp_load = 1'b0;
    out_load = 1'b0;
    clr_step = 1'b0;
    bloom_we = 1'b0;
    memo_we  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        // Zero each store only while the sweep is inside its depth.
        clr_step = 1'b1;
        bloom_we = ({1'b0, clr_cnt_r} < CNT_W'(BLOOM_DEPTH));
        memo_we  = ({1'b0, clr_cnt_r} < CNT_W'(MEMO_DEPTH));
      end
      ST_IDLE: in_ready = 1'b1;
      ST_MUL:  memo_re = 1'b1;
      ST_HASH: cmp_load = 1'b1;
      ST_BRD:  bloom_re = 1'b1;
      ST_DEC: begin
        // Hold the write-back until the result register can take the result.
        if (out_free) begin
          out_load = 1'b1;
          bloom_we = emit_c;
          memo_we  = (op_r == OP_PURE) && !hit_r;
        end
      end
      default: ;
    endcase
  end

  // Write port muxes: sweep during clear, otherwise the held event.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      bloom_wa = clr_cnt_r[BAW-1:0];
      bloom_wd = '0;
      memo_wa  = clr_cnt_r[MAW-1:0];
      memo_wd  = '0;
    end else begin
      bloom_wa = rep_key[BIT_SEL_W +: BAW];
      bloom_wd = bloom_rd_r | bit_mask;
      memo_wa  = memo_idx;
      memo_wd  = {1'b1, fh_r, a0_r, a1_r, res_r};
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_step) begin
        clr_cnt_r <= clr_cnt_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // Capture the transaction; hold it until the event retires.
    if (in_fire) begin
      op_r  <= op_t'(in_operation);
      pc_r  <= in_pc;
      fh_r  <= in_func_hash;
      a0_r  <= in_arg_first;
      a1_r  <= in_arg_second;
      res_r <= in_call_result;
    end
    if (cmp_load) begin
      hit_r   <= slot_hit;
      mis_r   <= slot_hit && (slot_res != res_r);
      prior_r <= slot_hit ? slot_res : '0;
    end
    if (out_load) begin
      emit_r      <= emit_c;
      mis_out_r   <= (op_r == OP_PURE) && mis_r;
      prior_out_r <= (op_r == OP_PURE) ? prior_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_emit_report  = emit_r;
  assign out_mismatch     = mis_out_r;
  assign out_prior_result = prior_out_r;

endmodule

// ===== tb/sv/tb_memo_result_checker_with_dedup.sv =====
// ----------------------------------------------------------------------------
// tb_memo_result_checker_with_dedup: self-checking bench for the memo checker
// Drives pure-call checks and direct fault reports through the valid/ready
// input channel. A scoreboard keeps its own memo table and report filter,
// predicts one verdict per accepted transaction and compares each result
// transaction against the oldest prediction. Sender bursts and gaps,
// receiver stalls and long receiver hold-offs exercise back-pressure.
// ----------------------------------------------------------------------------
module tb_memo_result_checker_with_dedup;
  import mrcd_pkg::*;

  localparam int N_RANDOM   = 1800;
  localparam int POOL_MAX   = 48;
  localparam int SITE_COUNT = 16;

  typedef struct packed {
    logic              emit;
    logic              mis;
    logic [DATA_W-1:0] prior;
  } verdict_t;

  // One pure call as the caller saw it; replayed to provoke memo hits.
  typedef struct packed {
    logic [DATA_W-1:0] fh;
    logic [DATA_W-1:0] a0;
    logic [DATA_W-1:0] a1;
    logic [DATA_W-1:0] res;
  } call_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow memo table plus shadow report filter. Every accepted
  // input transaction yields exactly one predicted verdict, queued in order.
  // --------------------------------------------------------------------------
  class memo_verdict_board;
    logic [DATA_W-1:0] filt_word [BLOOM_DEPTH_DEF];
    bit                memo_live [MEMO_DEPTH_DEF];
    logic [DATA_W-1:0] memo_fh   [MEMO_DEPTH_DEF];
    logic [DATA_W-1:0] memo_a0   [MEMO_DEPTH_DEF];
    logic [DATA_W-1:0] memo_a1   [MEMO_DEPTH_DEF];
    logic [DATA_W-1:0] memo_res  [MEMO_DEPTH_DEF];
    verdict_t          due_verdicts [$];
    int                errors;

    function new();
      foreach (filt_word[i]) filt_word[i] = '0;
      foreach (memo_live[i]) memo_live[i] = 1'b0;
      errors = 0;
    endfunction

    function string kind_text(input op_t kind);
      case (kind)
        OP_PURE:        return string'({"pure", "_inconsistency"});
        OP_OVERFLOW:    return "overflow";
        OP_UNREACHABLE: return "unreachable";
        OP_BOUNDS:      return string'({"bounds", "_violation"});
        OP_SIGN_CONV:   return string'({"sign", "_conversion"});
        OP_DIV_ZERO:    return string'({"division", "_by_zero"});
        OP_LOOP_BOUND:  return string'({"loop", "_bound_exceeded"});
        default:        return "";
      endcase
    endfunction

    // Fold the kind string into the site value, base 31, modulo 2^64.
    function logic [DATA_W-1:0] site_key(input logic [DATA_W-1:0] site, input op_t kind);
      string             s;
      logic [DATA_W-1:0] h;
      s = kind_text(kind);
      h = site;
      for (int i = 0; i < s.len(); i++) begin
        h = h * 64'd31 + {56'd0, s[i]};
      end
      return h;
    endfunction

    // Return 1 and set the bit when the report is new, else 0.
    function logic filter_admit(input logic [DATA_W-1:0] h);
      int unsigned w;
      w = int'((h >> BIT_SEL_W) % 64'(BLOOM_DEPTH_DEF));
      if (filt_word[w][h[BIT_SEL_W-1:0]]) return 1'b0;
      filt_word[w][h[BIT_SEL_W-1:0]] = 1'b1;
      return 1'b1;
    endfunction

    function void note_event(input op_t op, input logic [DATA_W-1:0] site,
                             input logic [DATA_W-1:0] fh, input logic [DATA_W-1:0] a0,
                             input logic [DATA_W-1:0] a1, input logic [DATA_W-1:0] res);
      verdict_t    v;
      int unsigned slot;
      v = '0;
      if (op == OP_PURE) begin
        slot = int'((fh ^ a0 ^ (a1 << 16)) % 64'(MEMO_DEPTH_DEF));
        if (memo_live[slot] && memo_fh[slot] == fh && memo_a0[slot] == a0 &&
            memo_a1[slot] == a1) begin
          v.prior = memo_res[slot];
          if (v.prior != res) begin
            v.mis  = 1'b1;
            v.emit = filter_admit(site_key(site, OP_PURE));
          end
        end else begin
          memo_fh[slot]   = fh;
          memo_a0[slot]   = a0;
          memo_a1[slot]   = a1;
          memo_res[slot]  = res;
          memo_live[slot] = 1'b1;
        end
      end else if (op != OP_UNUSED) begin
        v.emit = filter_admit(site_key(site, op));
      end
      due_verdicts.push_back(v);
    endfunction

    function void check_verdict(input logic emit, input logic mis,
                                input logic [DATA_W-1:0] prior);
      verdict_t v;
      if (due_verdicts.size() == 0) begin
        $error("result transaction with no prediction pending");
        errors++;
        return;
      end
      v = due_verdicts.pop_front();
      if (emit !== v.emit) begin
        $error("emit_report: expected %0d, actual %0d", v.emit, emit);
        errors++;
      end
      if (mis !== v.mis) begin
        $error("mismatch: expected %0d, actual %0d", v.mis, mis);
        errors++;
      end
      if (prior !== v.prior) begin
        $error("prior_result: expected %0d, actual %0d", $signed(v.prior), $signed(prior));
        errors++;
      end
    endfunction

    function int pending();
      return due_verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its ports
  // --------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation;
  logic [DATA_W-1:0]        in_pc;
  logic [DATA_W-1:0]        in_func_hash;
  logic signed [DATA_W-1:0] in_arg_first;
  logic signed [DATA_W-1:0] in_arg_second;
  logic signed [DATA_W-1:0] in_call_result;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_emit_report;
  logic                     out_mismatch;
  logic signed [DATA_W-1:0] out_prior_result;

  memo_verdict_board board = new();

  // Replay pool of stored calls and a small set of sites so that reports
  // repeat and the filter gets to deduplicate.
  call_t             recent_calls [$];
  logic [DATA_W-1:0] site_pool [SITE_COUNT];

  memo_result_checker_with_dedup u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_pc            (in_pc),
    .in_func_hash     (in_func_hash),
    .in_arg_first     (in_arg_first),
    .in_arg_second    (in_arg_second),
    .in_call_result   (in_call_result),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_emit_report  (out_emit_report),
    .out_mismatch     (out_mismatch),
    .out_prior_result (out_prior_result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous ceiling: reset sweep plus every transaction at its worst gap,
  // the block's own cycles and the receiver's longest stalls, several times.
  initial begin
    #1200000;
    $display("tb_memo_result_checker_with_dedup: done, errors");
    $finish;
  end

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one transaction at the falling edge and hold it until accepted.
  task automatic send_event(input op_t op, input logic [DATA_W-1:0] site,
                            input logic [DATA_W-1:0] fh, input logic [DATA_W-1:0] a0,
                            input logic [DATA_W-1:0] a1, input logic [DATA_W-1:0] res);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_pc          <= site;
    in_func_hash   <= fh;
    in_arg_first   <= a0;
    in_arg_second  <= a1;
    in_call_result <= res;
    do @(posedge clk); while (!in_ready);
    board.note_event(op, site, fh, a0, a1, res);
  endtask

  // Remember a stored call; drop the oldest once the pool is full.
  task automatic remember_call(input call_t c);
    recent_calls.push_back(c);
    if (recent_calls.size() > POOL_MAX) void'(recent_calls.pop_front());
  endtask

  // Pick one random event, weighted toward well-formed call sequences:
  // new calls, replays that hit, replays that disagree, slot conflicts,
  // then direct fault reports and a sprinkle of the unused code.
  task automatic send_random_event();
    call_t             c;
    int                pick;
    logic [DATA_W-1:0] site;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] slot;
    pick = $urandom_range(0, 99);
    site = ($urandom_range(0, 3) == 0) ? rand_word() : site_pool[$urandom_range(0, SITE_COUNT-1)];
    if (recent_calls.size() == 0 && pick >= 20 && pick < 65) pick = 0;
    if (pick < 20) begin
      c = {rand_word(), rand_word(), rand_word(), rand_word()};
      remember_call(c);
      send_event(OP_PURE, site, c.fh, c.a0, c.a1, c.res);
    end else if (pick < 40) begin
      c = recent_calls[$urandom_range(0, recent_calls.size()-1)];
      send_event(OP_PURE, site, c.fh, c.a0, c.a1, c.res);
    end else if (pick < 55) begin
      c = recent_calls[$urandom_range(0, recent_calls.size()-1)];
      c.res = ($urandom_range(0, 1) == 0) ? c.res + 64'd1 : rand_word();
      send_event(OP_PURE, site, c.fh, c.a0, c.a1, c.res);
    end else if (pick < 65) begin
      // Build a different key that lands in the slot of a stored call.
      c    = recent_calls[$urandom_range(0, recent_calls.size()-1)];
      mask = 64'(MEMO_DEPTH_DEF - 1);
      slot = (c.fh ^ c.a0 ^ (c.a1 << 16)) & mask;
      c.a0  = rand_word();
      c.a1  = rand_word();
      c.res = rand_word();
      c.fh  = (rand_word() & ~mask) | ((slot ^ c.a0 ^ (c.a1 << 16)) & mask);
      remember_call(c);
      send_event(OP_PURE, site, c.fh, c.a0, c.a1, c.res);
    end else if (pick < 95) begin
      send_event(op_t'($urandom_range(OP_OVERFLOW, OP_LOOP_BOUND)), site, rand_word(),
                 rand_word(), rand_word(), rand_word());
    end else begin
      send_event(OP_UNUSED, site, rand_word(), rand_word(), rand_word(), rand_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: reset, directed cases, then random bursts with random gaps.
  // --------------------------------------------------------------------------
  initial begin : sender
    int                burst_left;
    int                gap;
    logic [DATA_W-1:0] ones;
    logic [DATA_W-1:0] smin;
    logic [DATA_W-1:0] smax;
    ones = '1;
    smin = {1'b1, 63'd0};
    smax = {1'b0, {63{1'b1}}};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_UNUSED;
    in_pc          = '0;
    in_func_hash   = '0;
    in_arg_first   = '0;
    in_arg_second  = '0;
    in_call_result = '0;
    foreach (site_pool[i]) site_pool[i] = rand_word();
    site_pool[0] = '0;
    site_pool[1] = ones;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Unused code with every field at its top: no state change, all zero.
    send_event(OP_UNUSED, ones, ones, ones, ones, ones);
    // Zero key: miss, then hit with equal result, then two disagreeing
    // hits at the same site so the second report is deduplicated.
    send_event(OP_PURE, '0, '0, '0, '0, '0);
    send_event(OP_PURE, '0, '0, '0, '0, '0);
    send_event(OP_PURE, '0, '0, '0, '0, smax);
    send_event(OP_PURE, '0, '0, '0, '0, smin);
    // Extreme key: miss, equal hit, disagreeing hit at the top site.
    send_event(OP_PURE, ones, ones, smin, smax, ones);
    send_event(OP_PURE, ones, ones, smin, smax, ones);
    send_event(OP_PURE, ones, ones, smin, smax, 64'd1);
    // Same slot, different key (bit above the index): overwrite, then the
    // evicted key misses again.
    send_event(OP_PURE, ones, ones ^ (64'd1 << 10), smin, smax, smin);
    send_event(OP_PURE, ones, ones, smin, smax, ones);
    // Every fault kind, fresh and then repeated at the same site.
    for (int k = OP_OVERFLOW; k <= OP_LOOP_BOUND; k++) begin
      send_event(op_t'(k), '0, ones, smax, smin, ones);
    end
    for (int k = OP_OVERFLOW; k <= OP_LOOP_BOUND; k++) begin
      send_event(op_t'(k), '0, '0, '0, '0, '0);
    end
    send_event(OP_OVERFLOW, ones, '0, '0, '0, '0);
    send_event(OP_UNUSED, '0, '0, '0, '0, '0);

    burst_left = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      send_random_event();
      if (burst_left == 0) begin
        // Drop valid for a random gap, then start a new burst; some
        // bursts run long with no idling at all.
        gap = $urandom_range(1, 10);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every predicted verdict, then let the block settle.
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_memo_result_checker_with_dedup: done, clean");
    end else begin
      $display("tb_memo_result_checker_with_dedup: done, errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: segments of always-ready, random, stall-heavy and mostly-ready patterns.
  // Twice it holds off for a long stretch so the block backs up and stalls
  // its input while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int seg_count;
    int seg_len;
    int mode;
    out_ready = 1'b0;
    seg_count = 0;
    wait (in_ready === 1'b1);
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 80);
      if (seg_count == 6 || seg_count == 40) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (299) @(negedge clk);
      end else begin
        repeat (seg_len) begin
          @(negedge clk);
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
      seg_count++;
    end
  end

  // Check each result transaction at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_verdict(out_emit_report, out_mismatch, out_prior_result);
    end
  end

endmodule

// ===== files.f =====
src/mrcd_pkg.sv
src/mrcd_kind_hash.sv
src/memo_result_checker_with_dedup.sv
tb/sv/tb_memo_result_checker_with_dedup.sv
